// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and helpers for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int ARG_W     = 19;
  localparam int ROOT_W    = (ARG_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int NUM_W     = 17;
  localparam int MAG_W     = NUM_W;
  localparam int DIVN_W    = MAG_W + FRAC_BITS + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int Q_W       = DIVN_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = DIVN_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_FIRST = 2'd1,
    BR_SECOND = 2'd2,
    BR_THIRD = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [DW-1:0] r0c0, r0c1, r0c2;
    logic signed [DW-1:0] r1c0, r1c1, r1c2;
    logic signed [DW-1:0] r2c0, r2c1, r2c2;
  } matrix_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0]           branch_taken;
    logic                 degenerate;
  } quat_t;

  // classified item between front and back
  typedef struct packed {
    logic [ARG_W-1:0]      arg;
    logic                  degen;
    branch_t               branch;
    logic signed [NUM_W-1:0] n0, n1, n2;
  } job_t;

  function automatic logic signed [DW-1:0] sat16(input logic signed [Q_W:0] v);
    if (v > $signed({{(Q_W+1-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}}))
      return {1'b0, {(DW-1){1'b1}}};
    else if (v < -$signed({{(Q_W-DW+1){1'b0}}, 1'b1, {(DW-1){1'b0}}}))
      return {1'b1, {(DW-1){1'b0}}};
    else
      return v[DW-1:0];
  endfunction

endpackage

// ===== design/rmq_if.sv =====
// ----------------------------------------------------------------------------
// rmq_if
// Valid/ready channel carrying one payload of a parameterized type.
// ----------------------------------------------------------------------------
interface rmq_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch, forms the root argument and numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic            clk,
  input  logic            rst,
  rmq_if.sink             mat,
  output rmq_pkg::job_t   job,
  output logic            job_valid,
  input  logic            job_ready
);
  import rmq_pkg::*;

  logic signed [DW+1:0] tr, a1, a2, a3, a;
  logic signed [DW:0]   d_32_23, d_13_31, d_21_12, s_12_21, s_13_31, s_23_32;
  job_t job_next;
  localparam logic signed [DW+1:0] ONE = 18'sd1 <<< FRAC_BITS;

  assign mat.ready = !job_valid || job_ready;

  always_comb begin
    tr = 18'(mat.data.r0c0) + 18'(mat.data.r1c1) + 18'(mat.data.r2c2);
    a1 = ONE + 18'(mat.data.r0c0) - 18'(mat.data.r1c1) - 18'(mat.data.r2c2);
    a2 = ONE + 18'(mat.data.r1c1) - 18'(mat.data.r0c0) - 18'(mat.data.r2c2);
    a3 = ONE + 18'(mat.data.r2c2) - 18'(mat.data.r0c0) - 18'(mat.data.r1c1);
    d_32_23 = 17'(mat.data.r2c1) - 17'(mat.data.r1c2);
    d_13_31 = 17'(mat.data.r0c2) - 17'(mat.data.r2c0);
    d_21_12 = 17'(mat.data.r1c0) - 17'(mat.data.r0c1);
    s_12_21 = 17'(mat.data.r0c1) + 17'(mat.data.r1c0);
    s_13_31 = 17'(mat.data.r0c2) + 17'(mat.data.r2c0);
    s_23_32 = 17'(mat.data.r1c2) + 17'(mat.data.r2c1);
    job_next = '0;
    if (tr > 0) begin
      job_next.branch = BR_TRACE;
      a = ONE + tr;
      job_next.n0 = d_32_23; job_next.n1 = d_13_31; job_next.n2 = d_21_12;
    end else if (mat.data.r0c0 > mat.data.r1c1 && mat.data.r0c0 > mat.data.r2c2) begin
      job_next.branch = BR_FIRST;
      a = a1;
      job_next.n0 = d_32_23; job_next.n1 = s_12_21; job_next.n2 = s_13_31;
    end else if (mat.data.r1c1 > mat.data.r2c2) begin
      job_next.branch = BR_SECOND;
      a = a2;
      job_next.n0 = d_13_31; job_next.n1 = s_12_21; job_next.n2 = s_23_32;
    end else begin
      job_next.branch = BR_THIRD;
      a = a3;
      job_next.n0 = d_21_12; job_next.n1 = s_13_31; job_next.n2 = s_23_32;
    end
    job_next.degen = (a <= 0);
    job_next.arg   = job_next.degen ? '0 : ARG_W'(a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (mat.ready) begin
      job_valid <= mat.valid;
    end
    if (mat.valid && mat.ready) begin
      job <= job_next;
    end
  end

endmodule

// ===== design/rmq_fifo.sv =====
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue decoupling the classifier from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rmq_fifo (
  input  logic          clk,
  input  logic          rst,
  input  rmq_pkg::job_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output rmq_pkg::job_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import rmq_pkg::*;

  job_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   cnt;
  logic wr, rd;

  assign wr_ready = (cnt != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (QPTR_W+1)'(QDEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(rd_valid) |-> rp == wp)
    else $error("empty queue pointers differ");
  assert property (@(posedge clk) disable iff (rst) wr && !rd |=> cnt == $past(cnt) + 1'b1)
    else $error("count did not advance");

endmodule

// ===== design/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, then three pipelined dividers, then saturation.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic          clk,
  input  logic          rst,
  input  rmq_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  rmq_if.source         quat
);
  import rmq_pkg::*;

  localparam int S  = SQRT_STEPS;
  localparam int D  = DIV_STEPS;
  localparam int NS = S + D + 1;

  // square root stage registers
  logic [RAD_W-1:0]  s_rem [S+1];
  logic [ROOT_W-1:0] s_root [S+1];
  logic [RAD_W-1:0]  s_rad [S+1];
  job_t              s_job [S+1];
  // divider stage registers, three lanes
  logic [DIVN_W-1:0] d_num [3][D+1];
  logic [DEN_W:0]    d_rem [3][D+1];
  logic [Q_W-1:0]    d_q   [3][D+1];
  logic [ROOT_W-1:0] d_root [D+1];
  job_t              d_job [D+1];
  logic              vld [NS+1];
  logic              adv;
  quat_t             res_next;

  assign adv       = !quat.valid || quat.ready;
  assign job_ready = adv;

  always_comb begin
    s_rem[0]  = '0;
    s_root[0] = '0;
    s_rad[0]  = RAD_W'(job.arg) << FRAC_BITS;
    s_job[0]  = job;
  end

  // restoring square root, one result bit per stage
  for (genvar i = 0; i < S; i++) begin : g_sqrt
    logic [RAD_W+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {s_rem[i], s_rad[i][RAD_W-1 -: 2]};
      trial  = {s_root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          s_rem[i+1]  <= RAD_W'(rem_sh - trial);
          s_root[i+1] <= {s_root[i][ROOT_W-2:0], 1'b1};
        end else begin
          s_rem[i+1]  <= RAD_W'(rem_sh);
          s_root[i+1] <= {s_root[i][ROOT_W-2:0], 1'b0};
        end
        s_rad[i+1] <= s_rad[i] << 2;
        s_job[i+1] <= s_job[i];
      end
    end
  end

  // divider input: (|num| * ONE + r) / (2r)
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [NUM_W-1:0] n;
    logic [MAG_W-1:0] mag;
    always_comb begin
      case (l)
        0: n = s_job[S].n0;
        1: n = s_job[S].n1;
        default: n = s_job[S].n2;
      endcase
      mag = n[NUM_W-1] ? MAG_W'(-n) : MAG_W'(n);
      d_num[l][0] = (DIVN_W'(mag) << FRAC_BITS) + DIVN_W'(s_root[S]);
      d_rem[l][0] = '0;
      d_q[l][0]   = '0;
    end
    for (genvar i = 0; i < D; i++) begin : g_div
      logic [DEN_W+1:0] r_sh, den;
      always_comb begin
        r_sh = {d_rem[l][i], d_num[l][i][DIVN_W-1]};
        den  = (DEN_W+2)'({d_root[i], 1'b0});
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (r_sh >= den) begin
            d_rem[l][i+1] <= (DEN_W+1)'(r_sh - den);
            d_q[l][i+1]   <= {d_q[l][i][Q_W-2:0], 1'b1};
          end else begin
            d_rem[l][i+1] <= (DEN_W+1)'(r_sh);
            d_q[l][i+1]   <= {d_q[l][i][Q_W-2:0], 1'b0};
          end
          d_num[l][i+1] <= d_num[l][i] << 1;
        end
      end
    end
  end

  always_comb begin
    d_root[0] = s_root[S];
    d_job[0]  = s_job[S];
  end
  for (genvar i = 0; i < D; i++) begin : g_dpass
    always_ff @(posedge clk) begin
      if (adv) begin
        d_root[i+1] <= d_root[i];
        d_job[i+1]  <= d_job[i];
      end
    end
  end

  function automatic logic signed [DW-1:0] fin(input logic [Q_W-1:0] q,
                                               input logic neg);
    logic signed [Q_W:0] sq;
    sq = $signed({1'b0, q});
    return sat16(neg ? -sq : sq);
  endfunction

  always_comb begin
    logic signed [DW-1:0] big, c0, c1, c2;
    job_t j;
    j   = d_job[D];
    big = sat16((Q_W+1)'((d_root[D] + 1'b1) >> 1));
    c0  = fin(d_q[0][D], j.n0[NUM_W-1]);
    c1  = fin(d_q[1][D], j.n1[NUM_W-1]);
    c2  = fin(d_q[2][D], j.n2[NUM_W-1]);
    res_next = '0;
    res_next.branch_taken = j.branch;
    res_next.degenerate   = j.degen;
    if (!j.degen) begin
      case (j.branch)
        BR_TRACE: begin
          res_next.quat_w = big; res_next.quat_x = c0;
          res_next.quat_y = c1;  res_next.quat_z = c2;
        end
        BR_FIRST: begin
          res_next.quat_x = big; res_next.quat_w = c0;
          res_next.quat_y = c1;  res_next.quat_z = c2;
        end
        BR_SECOND: begin
          res_next.quat_y = big; res_next.quat_w = c0;
          res_next.quat_x = c1;  res_next.quat_z = c2;
        end
        default: begin
          res_next.quat_z = big; res_next.quat_w = c0;
          res_next.quat_x = c1;  res_next.quat_y = c2;
        end
      endcase
    end
  end

  assign vld[0] = job_valid;
  for (genvar i = 0; i < NS; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign quat.valid = vld[NS];
  always_ff @(posedge clk) begin
    if (adv) begin
      quat.data <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      quat.valid && quat.data.degenerate |->
      quat.data.quat_x == '0 && quat.data.quat_w == '0)
    else $error("degenerate result not zero");
  assert property (@(posedge clk) disable iff (rst)
      quat.valid && quat.data.degenerate |-> quat.data.branch_taken != BR_TRACE)
    else $error("trace branch flagged degenerate");
  assert property (@(posedge clk) disable iff (rst)
      !adv |=> $stable(quat.data))
    else $error("stalled result changed");

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Path: front register, queue, sqrt stages (17), divider stages (32), output register.
// Throughput: one matrix per cycle while quat.ready holds; the pipelined root and dividers set the rate.
// A four-entry queue decouples classification from the arithmetic pipeline.
// Reset (rst, synchronous): clears valid flags and queue pointers; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q2.14 rotation matrix to a saturated Q2.14 quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input logic clk,
  input logic rst,
  rmq_if.sink   mat,
  rmq_if.source quat
);
  import rmq_pkg::*;

  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  rmq_front u_front (
    .clk, .rst, .mat,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  rmq_fifo u_fifo (
    .clk, .rst,
    .wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  rmq_back u_back (
    .clk, .rst,
    .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .quat
  );

endmodule
